### design/rdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

	// Input item opcodes. Code 7 carries no operation.
	typedef enum logic [2:0] {
		OP_SYMBOL      = 3'd0,
		OP_ARM_LEARN   = 3'd1,
		OP_CANCEL      = 3'd2,
		OP_WR_KEY      = 3'd3,
		OP_WR_LEARNED  = 3'd4,
		OP_RD_LEARNED  = 3'd5,
		OP_CLR_LEARNED = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CHECK,
		ST_SCAN,
		ST_EMIT
	} state_t;

	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	localparam int DUR_W  = 15;
	localparam int KEY_W  = 32;
	localparam int OUT_CODE_W = 24;
	localparam int TALLY_W = 5;
	localparam int MASK_W = 8;
	localparam logic [TALLY_W-1:0] TALLY_MAX = 5'd31;

	typedef struct packed {
		logic [DUR_W-1:0] min_width;
		logic [DUR_W-1:0] win_lo;
		logic [DUR_W-1:0] win_hi;
		logic             controls_on;
	} cfg_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic check;
		logic scan_step;
		logic emit;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic frame_report;
		logic read_reply;
		logic go_scan;
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

### design/rf_remote_code_decoder.sv
// Decodes pulse-symbol frames from a 24-bit fixed-code RF remote. Each input item is either a
// symbol (high and low durations with their levels) or a key-table command; a symbol flagged
// frame_end yields one frame report, and a learned-key read yields one reply. An item is first
// taken in and then executed; a frame end adds a check step, and when keycode matching runs, a
// scan as one shared 32-bit comparator steps through the keycode slots; a reply then enters the
// output register, which lets the block take a new item while a result still waits. A reply
// that finds the output register still held waits for it, and no item is taken during that wait.
// Configuration is through an APB port at byte addresses 0, 4, 8 and 12.
`timescale 1ns / 1ps
`default_nettype none

module rf_remote_code_decoder
	import rdc_pkg::*;
#(
	parameter int NUM_KEYS  = 8,
	parameter int CODE_BITS = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [3:0]            paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [2:0]            opcode,
	input  wire logic [2:0]            slot,
	input  wire logic [31:0]           key_value,
	input  wire logic                  first_level,
	input  wire logic [14:0]           first_duration,
	input  wire logic                  second_level,
	input  wire logic [14:0]           second_duration,
	input  wire logic                  frame_end,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       result_kind,
	output logic                       code_valid,
	output logic [23:0]                decoded_code,
	output logic [4:0]                 timing_errors,
	output logic                       was_learned,
	output logic [7:0]                 match_mask,
	output logic [31:0]                read_data
);

	localparam logic [1:0] REG_MIN_WIDTH   = 2'd0;
	localparam logic [1:0] REG_WIN_LOW     = 2'd1;
	localparam logic [1:0] REG_WIN_HIGH    = 2'd2;
	localparam logic [1:0] REG_CONTROLS_ON = 2'd3;

	cfg_t       cfg_q;
	cmd_t       cmd;
	sts_t       sts;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_width   <= 15'd250;
			cfg_q.win_lo      <= 15'd560;
			cfg_q.win_hi      <= 15'd840;
			cfg_q.controls_on <= 1'b1;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MIN_WIDTH:   cfg_q.min_width   <= pwdata[DUR_W-1:0];
				REG_WIN_LOW:     cfg_q.win_lo      <= pwdata[DUR_W-1:0];
				REG_WIN_HIGH:    cfg_q.win_hi      <= pwdata[DUR_W-1:0];
				REG_CONTROLS_ON: cfg_q.controls_on <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MIN_WIDTH:   prdata = 32'(cfg_q.min_width);
			REG_WIN_LOW:     prdata = 32'(cfg_q.win_lo);
			REG_WIN_HIGH:    prdata = 32'(cfg_q.win_hi);
			REG_CONTROLS_ON: prdata = 32'(cfg_q.controls_on);
			default:         prdata = '0;
		endcase
	end

	rdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rdc_dp #(
		.NUM_KEYS  (NUM_KEYS),
		.CODE_BITS (CODE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.cmd             (cmd),
		.sts             (sts),
		.opcode          (opcode),
		.slot            (slot),
		.key_value       (key_value),
		.first_level     (first_level),
		.first_duration  (first_duration),
		.second_level    (second_level),
		.second_duration (second_duration),
		.frame_end       (frame_end),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.result_kind     (result_kind),
		.code_valid      (code_valid),
		.decoded_code    (decoded_code),
		.timing_errors   (timing_errors),
		.was_learned     (was_learned),
		.match_mask      (match_mask),
		.read_data       (read_data)
	);

endmodule

`default_nettype wire

### design/rdc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rdc_ctrl
	import rdc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				priority if (sts.frame_report) begin
					state_d = ST_CHECK;
				end else if (sts.read_reply) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = sts.go_scan ? ST_SCAN : ST_EMIT;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// The result waits here until the output register can take it.
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### design/rdc_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module rdc_dp
	import rdc_pkg::*;
#(
	parameter int NUM_KEYS  = 8,
	parameter int CODE_BITS = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cfg_t                  cfg,
	input  wire cmd_t                  cmd,
	output sts_t                       sts,
	input  wire logic [2:0]            opcode,
	input  wire logic [2:0]            slot,
	input  wire logic [KEY_W-1:0]      key_value,
	input  wire logic                  first_level,
	input  wire logic [DUR_W-1:0]      first_duration,
	input  wire logic                  second_level,
	input  wire logic [DUR_W-1:0]      second_duration,
	input  wire logic                  frame_end,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       result_kind,
	output logic                       code_valid,
	output logic [OUT_CODE_W-1:0]      decoded_code,
	output logic [TALLY_W-1:0]         timing_errors,
	output logic                       was_learned,
	output logic [MASK_W-1:0]          match_mask,
	output logic [KEY_W-1:0]           read_data
);

	localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int CW = $clog2(CODE_BITS + 1);

	// Item registers.
	logic [2:0]       op_q;
	logic [2:0]       slot_q;
	logic [KEY_W-1:0] key_q;
	logic             l0_q, l1_q, fend_q;
	logic [DUR_W-1:0] d0_q, d1_q;

	// Frame and key state.
	logic [CW-1:0]        cnt_q;
	logic [CODE_BITS-1:0] shift_q;
	logic [TALLY_W-1:0]   tally_q;
	logic                 bad_q;
	logic                 armed_q;
	logic [KW-1:0]        tgt_q;
	logic [KEY_W-1:0]     match_keys_q [NUM_KEYS];
	logic [KEY_W-1:0]     learned_q [NUM_KEYS];
	logic [KW-1:0]        idx_q;

	// Result under construction.
	logic                  res_kind_q, res_valid_q, res_learned_q;
	logic [OUT_CODE_W-1:0] res_code_q;
	logic [TALLY_W-1:0]    res_tally_q;
	logic [NUM_KEYS-1:0]   res_mask_q;
	logic [KEY_W-1:0]      res_rdata_q;

	// Output register.
	logic                  out_valid_q, out_kind_q, out_cvalid_q, out_learned_q;
	logic [OUT_CODE_W-1:0] out_code_q;
	logic [TALLY_W-1:0]    out_tally_q;
	logic [MASK_W-1:0]     out_mask_q;
	logic [KEY_W-1:0]      out_rdata_q;

	logic                 slot_ok;
	logic [KW-1:0]        slot_idx;
	logic                 sym_live;
	logic                 malformed;
	logic                 d0_gt;
	logic [DUR_W-1:0]     diff;
	logic                 timing_err;
	logic                 code_ok;
	logic [KEY_W-1:0]     code32;

	assign slot_ok  = ({1'b0, slot_q} < 4'(NUM_KEYS));
	assign slot_idx = KW'(slot_q);
	assign sym_live = !bad_q && (cnt_q < CW'(CODE_BITS));
	assign malformed = !(l0_q && !l1_q && (d0_q >= cfg.min_width) && (d1_q >= cfg.min_width));
	assign d0_gt    = d0_q > d1_q;
	assign diff     = d0_gt ? (d0_q - d1_q) : (d1_q - d0_q);
	assign timing_err = (diff < cfg.win_lo) || (diff > cfg.win_hi);
	assign code_ok  = !bad_q && (cnt_q >= CW'(CODE_BITS)) && (shift_q != '0);
	assign code32   = KEY_W'(shift_q);

	assign sts.frame_report = (op_q == OP_SYMBOL) && fend_q;
	assign sts.read_reply   = (op_q == OP_RD_LEARNED);
	assign sts.go_scan      = code_ok && !armed_q && cfg.controls_on;
	assign sts.scan_last    = (idx_q == KW'(NUM_KEYS - 1));
	assign sts.out_free     = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode;
			slot_q <= slot;
			key_q  <= key_value;
			l0_q   <= first_level;
			d0_q   <= first_duration;
			l1_q   <= second_level;
			d1_q   <= second_duration;
			fend_q <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			shift_q <= '0;
			tally_q <= '0;
			bad_q   <= 1'b0;
			armed_q <= 1'b0;
			tgt_q   <= '0;
			idx_q   <= '0;
			for (int i = 0; i < NUM_KEYS; i++) begin
				match_keys_q[i] <= '0;
				learned_q[i]    <= '0;
			end
		end else begin
			if (cmd.exec) begin
				unique case (op_q)
					OP_SYMBOL: begin
						if (sym_live) begin
							cnt_q <= cnt_q + CW'(1);
							if (malformed) begin
								bad_q <= 1'b1;
							end else begin
								shift_q <= {shift_q[CODE_BITS-2:0], d0_gt};
								if (timing_err && (tally_q < TALLY_MAX)) begin
									tally_q <= tally_q + TALLY_W'(1);
								end
							end
						end
					end
					OP_ARM_LEARN: begin
						if (slot_ok) begin
							armed_q <= 1'b1;
							tgt_q   <= slot_idx;
						end
					end
					OP_CANCEL: begin
						armed_q <= 1'b0;
					end
					OP_WR_KEY: begin
						if (slot_ok) begin
							match_keys_q[slot_idx] <= key_q;
						end
					end
					OP_WR_LEARNED: begin
						if (slot_ok) begin
							learned_q[slot_idx] <= key_q;
						end
					end
					OP_CLR_LEARNED: begin
						for (int i = 0; i < NUM_KEYS; i++) begin
							learned_q[i] <= '0;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.check) begin
				idx_q <= '0;
				if (code_ok && armed_q) begin
					learned_q[tgt_q] <= code32;
					armed_q          <= 1'b0;
				end
			end
			if (cmd.scan_step) begin
				idx_q <= idx_q + KW'(1);
			end
			// The frame state is kept through the keycode scan and cleared as the
			// report leaves.
			if (cmd.emit && (res_kind_q == KIND_FRAME)) begin
				cnt_q   <= '0;
				shift_q <= '0;
				tally_q <= '0;
				bad_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && (op_q == OP_RD_LEARNED)) begin
			res_kind_q    <= KIND_READ;
			res_valid_q   <= 1'b0;
			res_code_q    <= '0;
			res_tally_q   <= '0;
			res_learned_q <= 1'b0;
			res_mask_q    <= '0;
			res_rdata_q   <= slot_ok ? learned_q[slot_idx] : '0;
		end
		if (cmd.check) begin
			res_kind_q    <= KIND_FRAME;
			res_valid_q   <= code_ok;
			res_code_q    <= code_ok ? code32[OUT_CODE_W-1:0] : '0;
			res_tally_q   <= tally_q;
			res_learned_q <= code_ok && armed_q;
			res_mask_q    <= '0;
			res_rdata_q   <= '0;
		end
		if (cmd.scan_step && (match_keys_q[idx_q] == code32)) begin
			res_mask_q[idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q    <= res_kind_q;
			out_cvalid_q  <= res_valid_q;
			out_code_q    <= res_code_q;
			out_tally_q   <= res_tally_q;
			out_learned_q <= res_learned_q;
			out_mask_q    <= MASK_W'(res_mask_q);
			out_rdata_q   <= res_rdata_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = out_kind_q;
	assign code_valid    = out_cvalid_q;
	assign decoded_code  = out_code_q;
	assign timing_errors = out_tally_q;
	assign was_learned   = out_learned_q;
	assign match_mask    = out_mask_q;
	assign read_data     = out_rdata_q;

	a_tally_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		TALLY_W'(cnt_q) >= tally_q || cnt_q > CW'(TALLY_MAX))
		else $error("timing error tally exceeds symbols taken");

	a_learned_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_learned_q |-> out_cvalid_q && (out_mask_q == '0))
		else $error("learned report without a valid code or with matches");

	a_mask_needs_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_mask_q != '0) |-> out_cvalid_q && (out_kind_q == KIND_FRAME))
		else $error("match mask set on a report without a valid code");

	a_read_reply_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_kind_q == KIND_READ) |->
		!out_cvalid_q && (out_code_q == '0) && !out_learned_q && (out_tally_q == '0))
		else $error("read reply carries frame fields");

	a_emit_after_report: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && (res_kind_q == KIND_FRAME) |=> (cnt_q == '0) && !bad_q)
		else $error("frame state not cleared after a frame report");

endmodule

`default_nettype wire
